// ===== hw/rtl/tksl_pkg.sv =====
// ----------------------------------------------------------------------------
// tksl_pkg: shared types and constants for the top-K signal list
// Entry layout, request modes, unit command and status records.
// ----------------------------------------------------------------------------
package tksl_pkg;

    // List depth and histogram size
    localparam int MAX_ENTRIES   = 16;
    localparam int CHANNEL_SLOTS = 16;

    // Derived widths
    localparam int EN_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int HC_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CH_AW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;

    // Saturation limits and security mapping
    localparam logic [7:0]  HIST_MAX       = 8'hFF;
    localparam logic [15:0] SEEN_MAX       = 16'hFFFF;
    localparam logic [3:0]  AUTH_KNOWN_MAX = 4'd7;
    localparam logic [3:0]  SEC_UNKNOWN    = 4'd8;

    typedef enum logic [1:0] {
        MODE_CLEAR     = 2'd0,
        MODE_INSERT    = 2'd1,
        MODE_READ_SLOT = 2'd2,
        MODE_READ_CHAN = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [7:0] strength;
        logic [7:0]        channel;
        logic [3:0]        security;
        logic              hidden;
        logic [15:0]       tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Command from the top level to the list and histogram units
    typedef struct packed {
        logic       start;
        t_mode      mode;
        t_entry     entry;
        logic [3:0] slot;
    } t_cmd;

    typedef struct packed {
        logic            done;
        logic            slot_valid;
        t_entry          slot_data;
        logic [HC_W-1:0] held;
    } t_list_stat;

    typedef struct packed {
        logic       done;
        logic [7:0] count;
    } t_hist_stat;

endpackage

// ===== hw/rtl/tksl_ram.sv =====
// ----------------------------------------------------------------------------
// tksl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tksl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tksl_hist.sv =====
// ----------------------------------------------------------------------------
// tksl_hist: per-channel use histogram
// Counters live in a RAM; per-entry valid bits give the all-zero reset/clear.
// ----------------------------------------------------------------------------
module tksl_hist (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tksl_pkg::t_cmd        i_cmd,
    output tksl_pkg::t_hist_stat  o_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_QRY
    } t_state;

    t_state                                r_state, n_state;
    logic [tksl_pkg::CHANNEL_SLOTS-1:0]    r_vld, n_vld;
    logic [tksl_pkg::CH_AW-1:0]            r_idx, n_idx;
    logic                                  r_done, n_done;
    logic [7:0]                            r_count, n_count;

    logic                                  ram_we;
    logic                                  ram_re;
    logic [7:0]                            ram_wdata;
    logic [7:0]                            ram_rdata;
    logic [7:0]                            cur;
    logic                                  in_range;

    assign in_range = {1'b0, i_cmd.entry.channel} < 9'(tksl_pkg::CHANNEL_SLOTS);
    assign cur      = r_vld[r_idx] ? ram_rdata : 8'd0;

    tksl_ram #(
        .WIDTH (8),
        .DEPTH (tksl_pkg::CHANNEL_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    // Read-modify-write sequencer
    always_comb begin
        n_state   = r_state;
        n_vld     = r_vld;
        n_idx     = r_idx;
        n_done    = 1'b0;
        n_count   = r_count;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_wdata = cur + 8'd1;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_idx   = i_cmd.entry.channel[tksl_pkg::CH_AW-1:0];
                    n_count = 8'd0;
                    case (i_cmd.mode)
                        tksl_pkg::MODE_CLEAR: begin
                            n_vld  = '0;
                            n_done = 1'b1;
                        end
                        tksl_pkg::MODE_INSERT: begin
                            if (in_range) begin
                                ram_re  = 1'b1;
                                n_state = S_UPD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        tksl_pkg::MODE_READ_CHAN: begin
                            if (in_range) begin
                                ram_re  = 1'b1;
                                n_state = S_QRY;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_UPD: begin
                // saturating increment, counter stays at its ceiling
                if (cur != tksl_pkg::HIST_MAX) begin
                    ram_we = 1'b1;
                end
                n_vld[r_idx] = 1'b1;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            S_QRY: begin
                n_count = cur;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_done  <= n_done;
        end
        r_idx   <= n_idx;
        r_count <= n_count;
    end

    assign o_stat.done  = r_done;
    assign o_stat.count = r_count;

endmodule

// ===== hw/rtl/tksl_list.sv =====
// ----------------------------------------------------------------------------
// tksl_list: sorted entry list in RAM
// Insertion walks from the tail toward the head, one entry per cycle,
// shifting weaker entries down until the insertion point is found.
// ----------------------------------------------------------------------------
module tksl_list (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tksl_pkg::t_cmd        i_cmd,
    output tksl_pkg::t_list_stat  o_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE
    } t_state;

    localparam logic [tksl_pkg::HC_W-1:0] HC_MAX = tksl_pkg::HC_W'(tksl_pkg::MAX_ENTRIES);
    localparam logic [tksl_pkg::HC_W-1:0] HC_ONE = tksl_pkg::HC_W'(1);

    t_state                       r_state, n_state;
    logic [tksl_pkg::HC_W-1:0]    r_pos, n_pos;
    logic [tksl_pkg::HC_W-1:0]    r_held, n_held;
    tksl_pkg::t_entry             r_entry, n_entry;
    logic                         r_done, n_done;
    logic                         r_slot_valid, n_slot_valid;

    logic                         ram_we;
    logic                         ram_re;
    logic [tksl_pkg::EN_AW-1:0]   ram_waddr;
    logic [tksl_pkg::EN_AW-1:0]   ram_raddr;
    logic [tksl_pkg::ENTRY_W-1:0] ram_wdata;
    logic [tksl_pkg::ENTRY_W-1:0] ram_rdata;
    tksl_pkg::t_entry             rd_entry;

    logic [tksl_pkg::HC_W-1:0]    start_pos;
    logic [tksl_pkg::HC_W-1:0]    start_m1;
    logic [tksl_pkg::HC_W-1:0]    pos_m1;
    logic [tksl_pkg::HC_W-1:0]    pos_m2;
    logic [7:0]                   slot_x;
    logic [7:0]                   held_x;
    logic                         slot_ok;

    assign rd_entry  = tksl_pkg::t_entry'(ram_rdata);
    assign start_pos = (r_held == HC_MAX) ? HC_MAX : r_held;
    assign start_m1  = start_pos - HC_ONE;
    assign pos_m1    = r_pos - HC_ONE;
    assign pos_m2    = r_pos - tksl_pkg::HC_W'(2);
    assign slot_x    = 8'(i_cmd.slot);
    assign held_x    = 8'(r_held);
    assign slot_ok   = slot_x < held_x;

    tksl_ram #(
        .WIDTH (tksl_pkg::ENTRY_W),
        .DEPTH (tksl_pkg::MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Insertion / read sequencer
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_held       = r_held;
        n_entry      = r_entry;
        n_done       = 1'b0;
        n_slot_valid = r_slot_valid;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = r_pos[tksl_pkg::EN_AW-1:0];
        ram_raddr    = pos_m2[tksl_pkg::EN_AW-1:0];
        ram_wdata    = r_entry;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_slot_valid = 1'b0;
                    case (i_cmd.mode)
                        tksl_pkg::MODE_CLEAR: begin
                            n_held = '0;
                            n_done = 1'b1;
                        end
                        tksl_pkg::MODE_INSERT: begin
                            n_entry = i_cmd.entry;
                            n_pos   = start_pos;
                            if (start_pos == '0) begin
                                // empty list: goes straight to the head
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = i_cmd.entry;
                                n_held    = r_held + HC_ONE;
                                n_done    = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = start_m1[tksl_pkg::EN_AW-1:0];
                                n_state   = S_SCAN;
                            end
                        end
                        tksl_pkg::MODE_READ_SLOT: begin
                            n_slot_valid = slot_ok;
                            ram_re       = slot_ok;
                            ram_raddr    = slot_x[tksl_pkg::EN_AW-1:0];
                            n_done       = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // rd_entry holds the entry just above r_pos
                if ($signed(rd_entry.strength) < $signed(r_entry.strength)) begin
                    // weaker: shift it down (falls off the end when full)
                    if (r_pos < HC_MAX) begin
                        ram_we    = 1'b1;
                        ram_wdata = rd_entry;
                    end
                    n_pos = pos_m1;
                    if (pos_m1 == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        ram_re = 1'b1;
                    end
                end else begin
                    // insertion point found; dropped if it ranks past the end
                    if (r_pos < HC_MAX) begin
                        ram_we = 1'b1;
                    end
                    if (r_held < HC_MAX) begin
                        n_held = r_held + HC_ONE;
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PLACE: begin
                ram_we = 1'b1;
                if (r_held < HC_MAX) begin
                    n_held = r_held + HC_ONE;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held       <= '0;
            r_done       <= 1'b0;
            r_slot_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held       <= n_held;
            r_done       <= n_done;
            r_slot_valid <= n_slot_valid;
        end
        r_pos   <= n_pos;
        r_entry <= n_entry;
    end

    assign o_stat.done       = r_done;
    assign o_stat.slot_valid = r_slot_valid;
    assign o_stat.slot_data  = rd_entry;
    assign o_stat.held       = r_held;

    // Held count never exceeds the list depth
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HC_MAX)
        else $error("held count beyond list depth");

    // The scan position never sits at the head
    a_scan_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_pos != '0))
        else $error("scan position at head");

endmodule

// ===== hw/rtl/top_k_signal_sorted_list.sv =====
// ----------------------------------------------------------------------------
// top_k_signal_sorted_list: bounded top-K scan list with channel histogram
// An accepted request starts the list and histogram units; the result is
// staged once both are done. An in-range channel query adds a RAM read.
// Insert time grows with the kept count: the entry RAM is walked from the tail
// one slot per cycle. One request at a time.
// Throughput: the next request is taken from the cycle after the result is
// loaded into the output register; the result waits there without blocking.
// Reset (synchronous, active low): empty list, zero counters and histogram.
// ----------------------------------------------------------------------------
module top_k_signal_sorted_list (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic signed [7:0]  i_signal_strength,
    input  logic [7:0]         i_radio_channel,
    input  logic [3:0]         i_auth_code,
    input  logic               i_is_hidden,
    input  logic [15:0]        i_network_tag,
    input  logic [3:0]         i_slot_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_slot_valid,
    output logic signed [7:0]  o_slot_strength,
    output logic [7:0]         o_slot_channel,
    output logic [3:0]         o_slot_security,
    output logic               o_slot_hidden,
    output logic [15:0]        o_slot_tag,
    output logic [4:0]         o_kept_count,
    output logic [15:0]        o_seen_count,
    output logic signed [7:0]  o_best_strength,
    output logic [7:0]         o_channel_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                     r_state;
    logic                       r_start;
    tksl_pkg::t_mode            r_mode;
    tksl_pkg::t_entry           r_entry;
    logic [3:0]                 r_slot;
    logic [15:0]                r_seen;
    logic signed [7:0]          r_best;

    // result staging
    logic                       r_list_got;
    logic                       r_hist_got;
    logic                       r_stg_valid;
    tksl_pkg::t_entry           r_stg_entry;
    logic [tksl_pkg::HC_W-1:0]  r_stg_held;
    logic [7:0]                 r_stg_count;

    // output register
    logic                       r_out_valid;
    logic                       r_o_slot_valid;
    tksl_pkg::t_entry           r_o_entry;
    logic [4:0]                 r_o_kept;
    logic [15:0]                r_o_seen;
    logic signed [7:0]          r_o_best;
    logic [7:0]                 r_o_count;

    tksl_pkg::t_cmd             cmd;
    tksl_pkg::t_list_stat       s_list;
    tksl_pkg::t_hist_stat       s_hist;
    tksl_pkg::t_mode            in_mode;
    logic                       in_accept;
    logic                       list_got;
    logic                       hist_got;
    logic                       out_free;
    logic                       out_load;
    logic [3:0]                 in_security;

    assign in_mode     = tksl_pkg::t_mode'(i_mode);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_security = (i_auth_code <= tksl_pkg::AUTH_KNOWN_MAX) ? i_auth_code
                                                                   : tksl_pkg::SEC_UNKNOWN;
    assign list_got    = r_list_got || s_list.done;
    assign hist_got    = r_hist_got || s_hist.done;
    assign out_free    = !r_out_valid || i_out_ready;
    assign out_load    = (r_state == S_OUT) && out_free;

    assign cmd.start = r_start;
    assign cmd.mode  = r_mode;
    assign cmd.entry = r_entry;
    assign cmd.slot  = r_slot;

    tksl_list u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (s_list)
    );

    tksl_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (s_hist)
    );

    // Request control, global counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_seen      <= '0;
            r_best      <= '0;
            r_list_got  <= 1'b0;
            r_hist_got  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= in_accept;
            // output valid: set on load, cleared on handshake
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_mode           <= in_mode;
                        r_entry.strength <= i_signal_strength;
                        r_entry.channel  <= i_radio_channel;
                        r_entry.security <= in_security;
                        r_entry.hidden   <= i_is_hidden;
                        r_entry.tag      <= i_network_tag;
                        r_slot           <= i_slot_index;
                        r_state          <= S_WAIT;
                        if (in_mode == tksl_pkg::MODE_CLEAR) begin
                            r_seen <= '0;
                            r_best <= '0;
                        end else if (in_mode == tksl_pkg::MODE_INSERT) begin
                            // first entry after clear sets the best level outright
                            if (r_seen == '0 || i_signal_strength > r_best) begin
                                r_best <= i_signal_strength;
                            end
                            if (r_seen != tksl_pkg::SEEN_MAX) begin
                                r_seen <= r_seen + 16'd1;
                            end
                        end
                    end
                end
                S_WAIT: begin
                    if (s_list.done) begin
                        r_stg_valid <= s_list.slot_valid;
                        r_stg_entry <= s_list.slot_valid ? s_list.slot_data : '0;
                        r_stg_held  <= s_list.held;
                    end
                    if (s_hist.done) begin
                        r_stg_count <= s_hist.count;
                    end
                    if (list_got && hist_got) begin
                        r_list_got <= 1'b0;
                        r_hist_got <= 1'b0;
                        r_state    <= S_OUT;
                    end else begin
                        r_list_got <= list_got;
                        r_hist_got <= hist_got;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_slot_valid <= r_stg_valid;
                        r_o_entry      <= r_stg_entry;
                        r_o_kept       <= 5'(r_stg_held);
                        r_o_seen       <= r_seen;
                        r_o_best       <= r_best;
                        r_o_count      <= r_stg_count;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_slot_valid    = r_o_slot_valid;
    assign o_slot_strength = r_o_entry.strength;
    assign o_slot_channel  = r_o_entry.channel;
    assign o_slot_security = r_o_entry.security;
    assign o_slot_hidden   = r_o_entry.hidden;
    assign o_slot_tag      = r_o_entry.tag;
    assign o_kept_count    = r_o_kept;
    assign o_seen_count    = r_o_seen;
    assign o_best_strength = r_o_best;
    assign o_channel_count = r_o_count;

    // An accepted request starts the units on the next cycle
    a_start_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_start)
        else $error("request accepted without unit start");

    // Unit completions only while a request is in flight
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_list.done || s_hist.done) |-> (r_state == S_WAIT))
        else $error("unit done outside wait state");

    // The result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_out_ready) |=> (r_state == S_OUT))
        else $error("result register overwritten");

endmodule

// ===== sim/top_k_signal_sorted_list_tb.sv =====
// ----------------------------------------------------------------------------
// top_k_signal_sorted_list_tb: self-checking bench for the top-K scan list
// Drives clear, insert and read requests through the valid/ready channels,
// predicts every reply with a behavioral copy of the sorted list, counters
// and channel histogram, and compares each reply field by field. Runs three
// idling phases and a short insert soak that saturates one histogram counter.
// ----------------------------------------------------------------------------
module top_k_signal_sorted_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 40;
    localparam int SOAK_INSERTS = 260;   // a little past histogram saturation

    // One request and one reply as seen on the ports
    typedef struct packed {
        tksl_pkg::t_mode   mode;
        logic signed [7:0] strength;
        logic [7:0]        channel;
        logic [3:0]        auth;
        logic              hidden;
        logic [15:0]       tag;
        logic [3:0]        slot;
    } t_scan_req;

    typedef struct packed {
        logic              slot_valid;
        logic signed [7:0] slot_strength;
        logic [7:0]        slot_channel;
        logic [3:0]        slot_security;
        logic              slot_hidden;
        logic [15:0]       slot_tag;
        logic [4:0]        kept;
        logic [15:0]       seen;
        logic signed [7:0] best;
        logic [7:0]        chan_count;
    } t_scan_reply;

    // DUT ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_mode = 2'd0;
    logic signed [7:0]  i_signal_strength = 8'sd0;
    logic [7:0]         i_radio_channel = 8'd0;
    logic [3:0]         i_auth_code = 4'd0;
    logic               i_is_hidden = 1'b0;
    logic [15:0]        i_network_tag = 16'd0;
    logic [3:0]         i_slot_index = 4'd0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_slot_valid;
    logic signed [7:0]  o_slot_strength;
    logic [7:0]         o_slot_channel;
    logic [3:0]         o_slot_security;
    logic               o_slot_hidden;
    logic [15:0]        o_slot_tag;
    logic [4:0]         o_kept_count;
    logic [15:0]        o_seen_count;
    logic signed [7:0]  o_best_strength;
    logic [7:0]         o_channel_count;

    // Bench state
    t_scan_req   queued_reqs [$];
    t_scan_reply predicted_replies [$];
    t_scan_req   active_req;
    logic        req_taken;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          error_count = 0;
    int          reply_count = 0;
    int          reqs_queued = 0;
    int          stall_cycles = 0;

    // Behavioral copy of the list, counters and histogram
    tksl_pkg::t_entry  ranked [tksl_pkg::MAX_ENTRIES];
    int                ranked_cnt;
    logic [15:0]       seen_total;
    logic signed [7:0] best_level;
    logic [7:0]        chan_hist [tksl_pkg::CHANNEL_SLOTS];

    top_k_signal_sorted_list dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_signal_strength (i_signal_strength),
        .i_radio_channel   (i_radio_channel),
        .i_auth_code       (i_auth_code),
        .i_is_hidden       (i_is_hidden),
        .i_network_tag     (i_network_tag),
        .i_slot_index      (i_slot_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_slot_valid      (o_slot_valid),
        .o_slot_strength   (o_slot_strength),
        .o_slot_channel    (o_slot_channel),
        .o_slot_security   (o_slot_security),
        .o_slot_hidden     (o_slot_hidden),
        .o_slot_tag        (o_slot_tag),
        .o_kept_count      (o_kept_count),
        .o_seen_count      (o_seen_count),
        .o_best_strength   (o_best_strength),
        .o_channel_count   (o_channel_count)
    );

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Empty list, zero counters and histogram (reset and clear requests)
    function automatic void clear_scan_list();
        ranked_cnt = 0;
        seen_total = '0;
        best_level = '0;
        for (int i = 0; i < tksl_pkg::CHANNEL_SLOTS; i++) chan_hist[i] = '0;
    endfunction

    // Apply one request to the list copy and return the reply it yields
    function automatic t_scan_reply scan_list_step(input t_scan_req r);
        t_scan_reply      rep;
        tksl_pkg::t_entry fresh;
        int               pos;
        int               last;
        logic             found;
        rep = '0;
        case (r.mode)
            tksl_pkg::MODE_CLEAR: begin
                clear_scan_list();
            end
            tksl_pkg::MODE_INSERT: begin
                fresh.strength = r.strength;
                fresh.channel  = r.channel;
                fresh.security = (r.auth <= tksl_pkg::AUTH_KNOWN_MAX) ? r.auth
                                                                      : tksl_pkg::SEC_UNKNOWN;
                fresh.hidden   = r.hidden;
                fresh.tag      = r.tag;
                if (r.channel < tksl_pkg::CHANNEL_SLOTS &&
                    chan_hist[r.channel] != tksl_pkg::HIST_MAX)
                    chan_hist[r.channel] = chan_hist[r.channel] + 8'd1;
                // first entry after clear sets the best level, even if negative
                if (seen_total == 16'd0 || $signed(r.strength) > $signed(best_level))
                    best_level = r.strength;
                if (seen_total != tksl_pkg::SEEN_MAX) seen_total = seen_total + 16'd1;
                // insert ahead of the first strictly weaker entry
                pos = ranked_cnt;
                found = 1'b0;
                for (int i = 0; i < ranked_cnt; i++) begin
                    if (!found && $signed(r.strength) > $signed(ranked[i].strength)) begin
                        pos = i;
                        found = 1'b1;
                    end
                end
                if (pos < tksl_pkg::MAX_ENTRIES) begin
                    last = (ranked_cnt < tksl_pkg::MAX_ENTRIES) ? ranked_cnt
                                                                : tksl_pkg::MAX_ENTRIES - 1;
                    for (int i = last; i > pos; i--) ranked[i] = ranked[i - 1];
                    ranked[pos] = fresh;
                    if (ranked_cnt < tksl_pkg::MAX_ENTRIES) ranked_cnt++;
                end
            end
            tksl_pkg::MODE_READ_SLOT: begin
                if (r.slot < ranked_cnt) begin
                    rep.slot_valid    = 1'b1;
                    rep.slot_strength = ranked[r.slot].strength;
                    rep.slot_channel  = ranked[r.slot].channel;
                    rep.slot_security = ranked[r.slot].security;
                    rep.slot_hidden   = ranked[r.slot].hidden;
                    rep.slot_tag      = ranked[r.slot].tag;
                end
            end
            default: begin
                if (r.channel < tksl_pkg::CHANNEL_SLOTS) rep.chan_count = chan_hist[r.channel];
            end
        endcase
        rep.kept = ranked_cnt[4:0];
        rep.seen = seen_total;
        rep.best = best_level;
        return rep;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] reply %0d %s: got 0x%0h, expected 0x%0h",
                 $realtime, reply_count, field, got, want);
        error_count++;
    endtask

    // Stimulus builders
    task automatic queue_req(input tksl_pkg::t_mode m, input logic signed [7:0] s,
                             input logic [7:0] ch, input logic [3:0] auth,
                             input logic hid, input logic [15:0] tag,
                             input logic [3:0] slot);
        t_scan_req r;
        r.mode     = m;
        r.strength = s;
        r.channel  = ch;
        r.auth     = auth;
        r.hidden   = hid;
        r.tag      = tag;
        r.slot     = slot;
        queued_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic queue_random(input tksl_pkg::t_mode m);
        queue_req(m, 8'($urandom), 8'($urandom), 4'($urandom), 1'($urandom),
                  16'($urandom), 4'($urandom));
    endtask

    task automatic queue_insert(input logic signed [7:0] s, input logic [7:0] ch);
        queue_req(tksl_pkg::MODE_INSERT, s, ch, 4'($urandom), 1'($urandom),
                  16'($urandom), 4'($urandom));
    endtask

    // A scan pass: optional clear, a run of inserts, then reads of the list and of channel counts
    task automatic queue_scan_pass();
        int n;
        int style;
        int band;
        logic signed [7:0] s;
        logic [7:0] ch;
        n = $urandom_range(24, 1);
        style = $urandom_range(3);
        band = int'($urandom_range(100)) - 60;
        if ($urandom_range(2) == 0) queue_random(tksl_pkg::MODE_CLEAR);
        for (int i = 0; i < n; i++) begin
            case (style)
                0: s = 8'($urandom);                              // full range
                1: s = 8'(band + int'($urandom_range(3)));        // narrow band, many ties
                2: s = 8'(120 - 10 * i);                          // descending, tail drops
                default: s = 8'(-128 + int'($urandom_range(8)) * i); // rising or flat
            endcase
            ch = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(17));
            queue_insert(s, ch);
        end
        for (int i = $urandom_range(6, 2); i > 0; i--)
            queue_req(tksl_pkg::MODE_READ_SLOT, 8'($urandom), 8'($urandom), 4'($urandom),
                      1'($urandom), 16'($urandom), 4'($urandom_range(15)));
        for (int i = $urandom_range(2); i > 0; i--)
            queue_req(tksl_pkg::MODE_READ_CHAN, 8'($urandom), 8'($urandom_range(17)),
                      4'($urandom), 1'($urandom), 16'($urandom), 4'($urandom));
    endtask

    task automatic queue_random_phase(input int count);
        int start;
        start = reqs_queued;
        while (reqs_queued - start < count) begin
            if ($urandom_range(4) == 0) queue_random(tksl_pkg::t_mode'($urandom_range(3)));
            else queue_scan_pass();
        end
    endtask

    task automatic wait_all_idle();
        while (queued_reqs.size() != 0 || i_in_valid || predicted_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            req_taken = i_in_valid && o_in_ready;
            if (req_taken) predicted_replies.push_back(scan_list_step(active_req));
            if (!i_in_valid || req_taken) begin
                if (queued_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    active_req = queued_reqs.pop_front();
                    i_in_valid        <= 1'b1;
                    i_mode            <= active_req.mode;
                    i_signal_strength <= active_req.strength;
                    i_radio_channel   <= active_req.channel;
                    i_auth_code       <= active_req.auth;
                    i_is_hidden       <= active_req.hidden;
                    i_network_tag     <= active_req.tag;
                    i_slot_index      <= active_req.slot;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor and checker
    always @(posedge i_clk) begin
        t_scan_reply got;
        t_scan_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_slot_valid, o_slot_strength, o_slot_channel, o_slot_security,
                   o_slot_hidden, o_slot_tag, o_kept_count, o_seen_count,
                   o_best_strength, o_channel_count};
            if (predicted_replies.size() == 0) begin
                report_mismatch("unexpected reply", 32'(got.seen), 32'd0);
            end else begin
                want = predicted_replies.pop_front();
                if (got.slot_valid !== want.slot_valid)
                    report_mismatch("slot_valid", 32'(got.slot_valid),
                                    32'(want.slot_valid));
                if (got.slot_strength !== want.slot_strength)
                    report_mismatch("slot_strength", 32'(got.slot_strength),
                                    32'(want.slot_strength));
                if (got.slot_channel !== want.slot_channel)
                    report_mismatch("slot_channel", 32'(got.slot_channel),
                                    32'(want.slot_channel));
                if (got.slot_security !== want.slot_security)
                    report_mismatch("slot_security", 32'(got.slot_security),
                                    32'(want.slot_security));
                if (got.slot_hidden !== want.slot_hidden)
                    report_mismatch("slot_hidden", 32'(got.slot_hidden),
                                    32'(want.slot_hidden));
                if (got.slot_tag !== want.slot_tag)
                    report_mismatch("slot_tag", 32'(got.slot_tag), 32'(want.slot_tag));
                if (got.kept !== want.kept)
                    report_mismatch("kept_count", 32'(got.kept), 32'(want.kept));
                if (got.seen !== want.seen)
                    report_mismatch("seen_count", 32'(got.seen), 32'(want.seen));
                if (got.best !== want.best)
                    report_mismatch("best_strength", 32'(got.best), 32'(want.best));
                if (got.chan_count !== want.chan_count)
                    report_mismatch("channel_count", 32'(got.chan_count),
                                    32'(want.chan_count));
            end
            reply_count++;
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: no handshake on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("top_k_signal_sorted_list regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Sequence: reset, directed requests, three idling phases, histogram soak
    initial begin
        logic [7:0] soak_ch;
        clear_scan_list();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 14;
        recv_idle_pct = 77;

        // empty list reads
        queue_req(tksl_pkg::MODE_READ_SLOT, 8'sd0, 8'd0, 4'd0, 1'b0, 16'd0, 4'd0);
        queue_req(tksl_pkg::MODE_READ_CHAN, 8'sd0, 8'd0, 4'd0, 1'b0, 16'd0, 4'd15);
        // first insert is the weakest possible: best goes negative
        queue_req(tksl_pkg::MODE_INSERT, 8'sh80, 8'd0, 4'd0, 1'b0, 16'h0000, 4'd0);
        queue_req(tksl_pkg::MODE_INSERT, 8'sd127, 8'd15, 4'd7, 1'b1, 16'hFFFF, 4'd15);
        // tie at the top, channel past the histogram, unknown auth code
        queue_req(tksl_pkg::MODE_INSERT, 8'sd127, 8'd16, 4'd8, 1'b0, 16'h1234, 4'd0);
        // tie at the bottom, highest channel and auth code
        queue_req(tksl_pkg::MODE_INSERT, 8'sh80, 8'd255, 4'd15, 1'b1, 16'hABCD, 4'd0);
        queue_req(tksl_pkg::MODE_INSERT, 8'sd0, 8'd3, 4'd9, 1'b0, 16'h8001, 4'd0);
        for (int i = 0; i < 5; i++)
            queue_req(tksl_pkg::MODE_READ_SLOT, 8'sd0, 8'd0, 4'd0, 1'b0, 16'd0, 4'(i));
        queue_req(tksl_pkg::MODE_READ_SLOT, 8'sd0, 8'd0, 4'd0, 1'b0, 16'd0, 4'd15);
        queue_req(tksl_pkg::MODE_READ_CHAN, 8'sd0, 8'd15, 4'd0, 1'b0, 16'd0, 4'd0);
        queue_req(tksl_pkg::MODE_READ_CHAN, 8'sd0, 8'd16, 4'd0, 1'b0, 16'd0, 4'd0);
        queue_req(tksl_pkg::MODE_READ_CHAN, 8'sd0, 8'd255, 4'd0, 1'b0, 16'd0, 4'd0);
        queue_req(tksl_pkg::MODE_READ_CHAN, 8'sd0, 8'd0, 4'd0, 1'b0, 16'd0, 4'd0);
        // read slot and channel count requested in other modes
        queue_req(tksl_pkg::MODE_INSERT, 8'sd5, 8'd0, 4'd1, 1'b0, 16'h0F0F, 4'd0);
        queue_req(tksl_pkg::MODE_CLEAR, 8'sd127, 8'd0, 4'd0, 1'b1, 16'hFFFF, 4'd0);
        queue_req(tksl_pkg::MODE_READ_SLOT, 8'sd0, 8'd0, 4'd0, 1'b0, 16'd0, 4'd0);
        queue_req(tksl_pkg::MODE_READ_CHAN, 8'sd0, 8'd0, 4'd0, 1'b0, 16'd0, 4'd0);
        // first insert after clear, below zero
        queue_req(tksl_pkg::MODE_INSERT, -8'sd5, 8'd7, 4'd4, 1'b1, 16'h5A5A, 4'd0);
        queue_req(tksl_pkg::MODE_READ_SLOT, 8'sd0, 8'd0, 4'd0, 1'b0, 16'd0, 4'd0);

        queue_random_phase(120);
        wait_all_idle();

        send_idle_pct = 77;
        recv_idle_pct = 14;
        queue_random_phase(120);
        wait_all_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_phase(60);

        // soak: drive one histogram counter into saturation
        soak_ch = 8'($urandom_range(tksl_pkg::CHANNEL_SLOTS - 1));
        queue_random(tksl_pkg::MODE_CLEAR);
        for (int i = 0; i < SOAK_INSERTS; i++)
            queue_insert(8'($urandom), soak_ch);
        for (int i = 0; i < tksl_pkg::CHANNEL_SLOTS; i++)
            queue_req(tksl_pkg::MODE_READ_CHAN, 8'($urandom), 8'(i), 4'($urandom),
                      1'($urandom), 16'($urandom), 4'($urandom));
        for (int i = 0; i < tksl_pkg::MAX_ENTRIES; i++)
            queue_req(tksl_pkg::MODE_READ_SLOT, 8'($urandom), 8'($urandom), 4'($urandom),
                      1'($urandom), 16'($urandom), 4'(i));
        wait_all_idle();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("top_k_signal_sorted_list regression: pass");
        end else begin
            $display("top_k_signal_sorted_list regression: fail");
        end
        $finish;
    end

endmodule
